// File: design/rtd_r2t_pkg.sv
// Shared constants and table lookups for the RTD resistance-to-temperature converter.
`default_nettype none

package rtd_r2t_pkg;

  localparam int TABLE_POINTS = 21;
  localparam int IDX_W        = 5;
  localparam int RES_W        = 16;
  localparam int SPAN_W       = 10;
  localparam int TEMP_W       = 12;
  localparam int STAT_W       = 2;
  localparam int QUO_W        = 7;

  localparam logic [RES_W-1:0] TABLE_LO = 16'd7909;
  localparam logic [RES_W-1:0] TABLE_HI = 16'd17993;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BELOW = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ABOVE = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  // Ni1000 resistance in 0.1 ohm at -50 C + 10 C * idx
  function automatic logic [RES_W-1:0] tbl_entry(input idx_t idx);
    logic [RES_W-1:0] val;
    case (idx)
      5'd0:    val = 16'd7909;
      5'd1:    val = 16'd8308;
      5'd2:    val = 16'd8717;
      5'd3:    val = 16'd9135;
      5'd4:    val = 16'd9562;
      5'd5:    val = 16'd10000;
      5'd6:    val = 16'd10448;
      5'd7:    val = 16'd10907;
      5'd8:    val = 16'd11376;
      5'd9:    val = 16'd11857;
      5'd10:   val = 16'd12350;
      5'd11:   val = 16'd12854;
      5'd12:   val = 16'd13371;
      5'd13:   val = 16'd13901;
      5'd14:   val = 16'd14444;
      5'd15:   val = 16'd15000;
      5'd16:   val = 16'd15570;
      5'd17:   val = 16'd16154;
      5'd18:   val = 16'd16752;
      5'd19:   val = 16'd17365;
      5'd20:   val = 16'd17993;
      default: val = 16'd17993;
    endcase
    return val;
  endfunction

  // Interval base temperature: 100*idx - 500, 0.1 C, two's complement
  function automatic logic [TEMP_W-1:0] tbl_base(input idx_t idx);
    logic [TEMP_W-1:0] prod;
    prod = ({7'd0, idx} << 6) + ({7'd0, idx} << 5) + ({7'd0, idx} << 2);
    return prod - 12'd500;
  endfunction

endpackage

`default_nettype wire

// File: design/rtd_resistance_to_temperature.sv
// Top level of the Ni1000 RTD resistance-to-temperature converter.
`default_nettype none

// Converts a Ni1000 resistance sample (0.1 ohm) to temperature (0.1 C) by
// linear interpolation in a 21-point table spanning -50 C to +150 C. Each
// input beat gives exactly one output beat. In range, the result is
// 100*(r - lo)/(hi - lo) + 100*i - 500 with truncation and becomes the held
// temperature. Below 790.9 ohm status is 1, at or above 1799.3 ohm status
// is 2; both repeat the held temperature (0 after reset). One sample is
// handled at a time: an in-range sample passes through operand setup and
// divider load, the 16 iterations of the bit-serial divider and result
// capture before output valid, an out-of-range one goes straight to the
// output state. in_stall stays high until the output beat has been taken,
// so no new sample is accepted before then.
module rtd_resistance_to_temperature
  import rtd_r2t_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [RES_W-1:0]         resistance,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [TEMP_W-1:0]      temperature,
  output logic [STAT_W-1:0]             status
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_OUT   = 3'd3;

  logic [2:0]        state;
  logic [RES_W-1:0]  res_q;
  idx_t              idx_q;
  idx_t              idx_find;
  logic [TEMP_W-1:0] last_temperature;

  logic [RES_W-1:0]  lo;
  logic [SPAN_W-1:0] delta;
  logic [SPAN_W-1:0] span;
  logic [RES_W-1:0]  numer;
  logic              div_start;
  logic              div_done;
  logic [RES_W-1:0]  quo;
  logic [TEMP_W-1:0] temp_calc;

  // interval search: independent compares against the constant table
  always_comb begin
    idx_find = '0;
    for (int j = 1; j < TABLE_POINTS - 1; j++) begin
      if (resistance >= tbl_entry(IDX_W'(j))) idx_find = IDX_W'(j);
    end
  end

  // operands for the divider, from the registered sample
  assign lo    = tbl_entry(idx_q);
  assign delta = SPAN_W'(res_q - lo);
  assign span  = SPAN_W'(tbl_entry(idx_q + 5'd1) - lo);
  // 100 * delta as shifts; delta < 628 keeps it within 16 bits
  assign numer = ({6'd0, delta} << 6) + ({6'd0, delta} << 5) + ({6'd0, delta} << 2);

  assign div_start = (state == ST_SETUP);

  rtd_r2t_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numer),
    .divisor  (span),
    .done     (div_done),
    .quotient (quo)
  );

  // quotient is always below 100
  assign temp_calc = {5'd0, quo[QUO_W-1:0]} + tbl_base(idx_q);

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign temperature = last_temperature;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      last_temperature <= '0;
      status           <= STATUS_OK;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (resistance < TABLE_LO) begin
              status <= STATUS_BELOW;
              state  <= ST_OUT;
            end else if (resistance >= TABLE_HI) begin
              status <= STATUS_ABOVE;
              state  <= ST_OUT;
            end else begin
              status <= STATUS_OK;
              state  <= ST_SETUP;
            end
          end
        end
        ST_SETUP: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            last_temperature <= temp_calc;
            state            <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sample and interval, captured on the input beat
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      res_q <= resistance;
      idx_q <= idx_find;
    end
  end

endmodule

`default_nettype wire

// File: design/rtd_r2t_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit dividend by 10-bit divisor.
`default_nettype none

module rtd_r2t_div
  import rtd_r2t_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RES_W-1:0]  dividend,
  input  wire logic [SPAN_W-1:0] divisor,
  output logic                   done,
  output logic [RES_W-1:0]       quotient
);

  logic              busy;
  logic [3:0]        cnt;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] dvs;
  logic [SPAN_W+1:0] diff;
  logic              neg;

  // trial subtract of the divisor from the shifted partial remainder
  assign diff = {1'b0, rem, quotient[RES_W-1]} - {2'b0, dvs};
  assign neg  = diff[SPAN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= neg ? {rem[SPAN_W-2:0], quotient[RES_W-1]} : diff[SPAN_W-1:0];
      quotient <= {quotient[RES_W-2:0], ~neg};
    end
  end

endmodule

`default_nettype wire

// File: sim/rtd_temperature_checker.sv
// Beat monitor and scoreboard for the Ni1000 resistance-to-temperature converter.
`timescale 1ns / 100ps

module rtd_temperature_checker
  import rtd_r2t_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [RES_W-1:0]         resistance,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic [STAT_W-1:0]        status,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [STAT_W-1:0]        stat;
  } reading_t;

  // Ni1000 table, 0.1 ohm, -50 C upward in 10 C steps; entry k at [k*RES_W +: RES_W]
  localparam logic [TABLE_POINTS*RES_W-1:0] NI_POINTS = {
    16'd17993, 16'd17365, 16'd16752, 16'd16154, 16'd15570,
    16'd15000, 16'd14444, 16'd13901, 16'd13371, 16'd12854,
    16'd12350, 16'd11857, 16'd11376, 16'd10907, 16'd10448,
    16'd10000, 16'd9562,  16'd9135,  16'd8717,  16'd8308,
    16'd7909
  };

  reading_t                 expected_readings [$];
  logic signed [TEMP_W-1:0] held_temp;
  int                       fails = 0;

  function automatic reading_t convert_resistance(input logic [RES_W-1:0] r,
                                                  input logic signed [TEMP_W-1:0] held);
    reading_t res;
    int       seg;
    int       lo;
    int       span;
    int       frac;
    res.temp = held;
    if (r < TABLE_LO) begin
      res.stat = STATUS_BELOW;
    end else if (r >= TABLE_HI) begin
      res.stat = STATUS_ABOVE;
    end else begin
      seg = 0;
      while (seg < TABLE_POINTS - 2 && NI_POINTS[(seg + 1) * RES_W +: RES_W] <= r)
        seg++;
      lo   = NI_POINTS[seg * RES_W +: RES_W];
      span = NI_POINTS[(seg + 1) * RES_W +: RES_W] - lo;
      frac = (100 * (int'(r) - lo)) / span;
      res.temp = TEMP_W'(frac + 100 * seg - 500);
      res.stat = STATUS_OK;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      held_temp = '0;
      expected_readings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat temperature=%0d status=%0d",
                                  temperature, status));
        end else begin
          want = expected_readings.pop_front();
          if (temperature !== want.temp)
            flag_mismatch($sformatf("temperature got %0d want %0d", temperature, want.temp));
          if (status !== want.stat)
            flag_mismatch($sformatf("status got %0d want %0d", status, want.stat));
        end
      end
      if (in_valid && !in_stall) begin
        want = convert_resistance(resistance, held_temp);
        if (want.stat == STATUS_OK)
          held_temp = want.temp;
        expected_readings.push_back(want);
      end
    end
    pending    <= expected_readings.size();
    fail_count <= fails;
  end

endmodule

// File: sim/rtd_resistance_to_temperature_test.sv
// Top of the testbench for the Ni1000 resistance-to-temperature converter.
`timescale 1ns / 100ps

module rtd_resistance_to_temperature_test;
  import rtd_r2t_pkg::*;

  // A correct run ends well before the limit: conversions plus
  // random sender gaps and receiver stalls on ~420 beats.
  localparam int CYCLE_LIMIT = 400000;
  // Drain a bit past the slowest in-range conversion.
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BEATS = 100;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [RES_W-1:0]         resistance;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] temperature;
  logic [STAT_W-1:0]        status;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // Idle odds, in percent, for the current phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  rtd_resistance_to_temperature DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .resistance  (resistance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temperature (temperature),
    .status      (status)
  );

  // Watches both channels, predicts each result beat and scores it.
  rtd_temperature_checker readings_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .resistance  (resistance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temperature (temperature),
    .status      (status),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rtd_resistance_to_temperature_test: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: one draw per cycle, changed on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Drives one input beat. Entered and left on a falling edge; any idle
  // cycles come first, with junk on the data lines while valid is low.
  task automatic send_beat(input logic [RES_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      resistance <= RES_W'($urandom);
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    resistance <= r;
    // hold the beat until the block takes it
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Mostly in-range samples, which take the divider path; the rest probe
  // the table edges, the region below it and the full 16-bit span.
  function automatic logic [RES_W-1:0] random_resistance();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70)
      return RES_W'($urandom_range(TABLE_HI - 1, TABLE_LO));
    else if (sel < 78)
      return RES_W'($urandom_range(TABLE_LO + 3, TABLE_LO - 3));
    else if (sel < 86)
      return RES_W'($urandom_range(TABLE_HI + 3, TABLE_HI - 3));
    else if (sel < 93)
      return RES_W'($urandom_range(TABLE_LO - 1, 0));
    else
      return RES_W'($urandom);
  endfunction

  initial begin
    int phase_send [4];
    int phase_recv [4];
    // no idling, sender idle, receiver stalling, both
    phase_send = '{0, 69, 0, 28};
    phase_recv = '{0, 0, 69, 28};

    rst        = 1'b1;
    in_valid   = 1'b0;
    resistance = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners, back to back.
    // Out-of-range before any in-range sample: held value is the reset zero.
    send_beat(16'd0);
    send_beat(TABLE_LO - 16'd1);
    send_beat(16'hFFFF);
    send_beat(TABLE_HI);
    // First table entry exactly (-50.0 C) and just past it.
    send_beat(TABLE_LO);
    send_beat(TABLE_LO + 16'd1);
    // Either side of an interior entry, then the 0 C point.
    send_beat(16'd8307);
    send_beat(16'd8308);
    send_beat(16'd10000);
    send_beat(16'd12349);
    send_beat(16'd15000);
    // Last interval: its base entry and the top just below the table end.
    send_beat(16'd17364);
    send_beat(16'd17365);
    send_beat(TABLE_HI - 16'd1);
    // Out of range again now holds the last in-range temperature.
    send_beat(TABLE_HI);
    send_beat(TABLE_HI + 16'd1);
    send_beat(TABLE_LO - 16'd1);
    send_beat(16'd1);
    // Alternating bit patterns and the sign bit of the data lines.
    send_beat(16'h5555);
    send_beat(16'hAAAA);
    send_beat(16'h7FFF);
    send_beat(16'h8000);
    send_beat(16'd10447);

    // Random part, one phase per idling mix.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      for (int n = 0; n < RANDOM_BEATS; n++)
        send_beat(random_resistance());
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("rtd_resistance_to_temperature_test: PASS");
    else
      $display("rtd_resistance_to_temperature_test: FAIL");
    $finish;
  end

endmodule
